// ===== rtl/core/ils_pkg.sv =====
// Package for the indexed list store: sizes, operation codes and port widths.
`default_nettype none
package ils_pkg;

    localparam int unsigned ILS_CAPACITY = 256;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned POS_W   = 16;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned LEN_W   = 9;

    // s_axis_tdata: position, item_value; padded to whole bytes
    localparam int unsigned IN_DATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
    // m_axis_tdata: read_value, length; padded to whole bytes
    localparam int unsigned OUT_DATA_W = ((VAL_W + LEN_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

endpackage
`default_nettype wire

// ===== rtl/core/ils_mem.sv =====
// Entry memory: one write port, one read port, registered read data.
`default_nettype none
module ils_mem
    import ils_pkg::*;
#(
    parameter int unsigned DEPTH = ILS_CAPACITY,
    parameter int unsigned AW    = $clog2(ILS_CAPACITY)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [VAL_W-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/indexed_list_store_top.sv =====
// Top level of the indexed list store: position-addressed list held in one memory.
`default_nettype none
// An ordered list of up to CAPACITY signed 32-bit values, addressed by
// position (0 is the head). Each input transfer carries an operation in
// s_axis_tuser (insert, remove or read) with a position and a value in
// s_axis_tdata; each one yields exactly one output transfer with the ok
// flag in m_axis_tuser and the read value and new length in m_axis_tdata.
// Insert works for positions 0 through the length and fails on a full
// store; remove and read work for positions below the length; a negative
// position or the unused operation code fails with the list unchanged.
// Entries live in a single memory with one write and one registered read
// port, so an insert or remove moves the later entries one per cycle with
// a read of one entry overlapped with the write of the one before.
// Items are taken one at a time. An insert or remove takes longer the nearer
// its position lies to the head, as it shifts the later entries through the
// memory port; the longest ones shift the whole list. A finished result
// waits in the output register while the next item is taken.
// Memory contents are not cleared; reset only empties the list.
module indexed_list_store_top
    import ils_pkg::*;
#(
    parameter int unsigned CAPACITY = ILS_CAPACITY
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [15:0] position, [47:16] item_value
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] operation
    input  wire logic [OP_W-1:0]       s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [31:0] read_value, [40:32] length, [47:41] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // [0] ok
    output logic                       m_axis_tuser
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    // wide enough for a position, a count and one more
    localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PUT,
        S_RD,
        S_DONE
    } t_state;

    t_state            r_state;
    t_op               r_op;
    logic [AW-1:0]     r_pos;
    logic [VAL_W-1:0]  r_val;
    logic [CW-1:0]     r_count;
    logic [AW-1:0]     r_idx;     // next read address during a shift
    logic [AW-1:0]     r_stop;    // last read address of a shift
    logic [AW-1:0]     r_wa;      // write address for the read in flight
    logic              r_issue;   // reads still to be issued
    logic              r_pend;    // read data arriving this cycle
    logic              r_res_ok;
    logic [VAL_W-1:0]  r_res_val;
    logic              r_out_valid;
    logic              r_out_ok;
    logic [VAL_W-1:0]  r_out_val;
    logic [LEN_W-1:0]  r_out_len;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [VAL_W-1:0]  mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [VAL_W-1:0]  mem_rdata;

    logic              in_xfer;
    t_op               in_op;
    logic              in_neg;
    logic [XW-1:0]     in_pos;
    logic [XW-1:0]     cnt_x;
    logic [AW-1:0]     n_idx;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign in_op         = t_op'(s_axis_tuser);
    assign in_neg        = s_axis_tdata[POS_W-1];
    assign in_pos        = XW'(s_axis_tdata[POS_W-2:0]);
    assign cnt_x         = XW'(r_count);

    assign n_idx = (r_op == OP_INSERT) ? (r_idx - AW'(1)) : (r_idx + AW'(1));

    // Memory ports: shift reads/writes, the final insert write, the read lookup
    always_comb begin
        mem_raddr = AW'(in_pos);
        if (r_state == S_SHIFT) begin
            mem_raddr = r_idx;
        end
        mem_we    = 1'b0;
        mem_waddr = r_wa;
        mem_wdata = mem_rdata;
        if (r_state == S_SHIFT && r_pend) begin
            mem_we = 1'b1;
        end else if (r_state == S_PUT) begin
            mem_we    = 1'b1;
            mem_waddr = r_pos;
            mem_wdata = r_val;
        end
    end

    ils_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the output once the consumer takes it; in S_DONE the
            // output register is refilled instead
            if (m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_op      <= in_op;
                        r_pos     <= AW'(in_pos);
                        r_val     <= s_axis_tdata[POS_W +: VAL_W];
                        r_res_ok  <= 1'b0;
                        r_res_val <= '0;
                        r_issue   <= 1'b0;
                        r_pend    <= 1'b0;
                        r_state   <= S_DONE;
                        if (!in_neg) begin
                            unique case (in_op)
                                OP_INSERT: begin
                                    if (in_pos <= cnt_x && cnt_x < XW'(CAPACITY)) begin
                                        r_res_ok <= 1'b1;
                                        if (cnt_x > in_pos) begin
                                            // move entries P..L-1 up, from the top
                                            r_idx   <= AW'(cnt_x - XW'(1));
                                            r_stop  <= AW'(in_pos);
                                            r_issue <= 1'b1;
                                            r_state <= S_SHIFT;
                                        end else begin
                                            r_state <= S_PUT;
                                        end
                                    end
                                end
                                OP_REMOVE: begin
                                    if (in_pos < cnt_x) begin
                                        r_res_ok <= 1'b1;
                                        if (in_pos + XW'(1) < cnt_x) begin
                                            // move entries P+1..L-1 down, from the bottom
                                            r_idx   <= AW'(in_pos + XW'(1));
                                            r_stop  <= AW'(cnt_x - XW'(1));
                                            r_issue <= 1'b1;
                                            r_state <= S_SHIFT;
                                        end else begin
                                            r_count <= r_count - CW'(1);
                                        end
                                    end
                                end
                                OP_READ: begin
                                    // memory lookup issued this cycle
                                    if (in_pos < cnt_x) begin
                                        r_res_ok <= 1'b1;
                                        r_state  <= S_RD;
                                    end
                                end
                                default: begin
                                    r_res_ok <= 1'b0;
                                end
                            endcase
                        end
                    end
                end
                S_SHIFT: begin
                    r_pend <= r_issue;
                    if (r_issue) begin
                        r_wa <= (r_op == OP_INSERT) ? (r_idx + AW'(1))
                                                    : (r_idx - AW'(1));
                        if (r_idx == r_stop) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= n_idx;
                        end
                    end else if (r_pend) begin
                        // last moved entry is written this cycle
                        if (r_op == OP_INSERT) begin
                            r_state <= S_PUT;
                        end else begin
                            r_count <= r_count - CW'(1);
                            r_state <= S_DONE;
                        end
                    end
                end
                S_PUT: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_DONE;
                end
                S_RD: begin
                    r_res_val <= mem_rdata;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    // hold the result until the output register is free
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_ok    <= r_res_ok;
                        r_out_val   <= r_res_val;
                        r_out_len   <= LEN_W'(r_count);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_ok;
    assign m_axis_tdata  = {(OUT_DATA_W - VAL_W - LEN_W)'(0), r_out_len, r_out_val};

endmodule
`default_nettype wire

// ===== rtl/core/ils_checker.sv =====
// Port-level checker for the indexed list store, bound to the top level.
`default_nettype none
module ils_checker
    import ils_pkg::*;
#(
    parameter int unsigned CAPACITY = ILS_CAPACITY
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input wire logic [OP_W-1:0]       s_axis_tuser,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                  m_axis_tuser
);

    // one item at a time: the input closes right after a transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in progress");

    // an offered item stays steady until it is taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata)
            && $stable(s_axis_tuser))
        else $error("input changed while waiting");

    // a failed operation carries a zero read value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[VAL_W-1:0] == '0)
        else $error("failed result with nonzero read value");

    // the reported length never exceeds the store size
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (CAPACITY > 511) ||
            (32'(m_axis_tdata[VAL_W +: LEN_W]) <= CAPACITY))
        else $error("length beyond capacity");

    // a result held back by the consumer stays steady
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output changed while stalled");

endmodule

bind indexed_list_store_top ils_checker #(
    .CAPACITY (CAPACITY)
) u_ils_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== tb/indexed_list_store_top_test.sv =====
// Self-checking stream testbench for the indexed list store top level.
`default_nettype none
module indexed_list_store_top_test;
    import ils_pkg::*;

    // Allow for the slowest run: every insert shifting the whole store,
    // the longest sender gap and receiver stall per item, and the long hold.
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 500;
    localparam int DIRECTED_ROWS = 25;
    localparam int HOLD_CYCLES   = 1000;
    localparam int FULL_ITEMS    = 30;

    // One output transfer as it is compared: ok, read value, new length.
    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] rd;
        logic [LEN_W-1:0] len;
    } t_list_result;

    // One directed stimulus row; the typed-in result is used when fixed_want is set.
    typedef struct packed {
        t_op              op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        logic             fixed_want;
        t_list_result     want;
    } t_list_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [15:0] position, [47:16] item_value
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // [1:0] operation
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [31:0] read_value, [40:32] length, [47:41] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [0] ok
    logic                  m_axis_tuser;

    // Shadow copy of the list, advanced on every accepted input transfer.
    logic signed [VAL_W-1:0] shadow_entries [ILS_CAPACITY];
    int                      shadow_len;

    t_list_result pending_results [$];
    t_list_row    dir_rows [DIRECTED_ROWS];

    int mismatch_count = 0;
    int results_seen   = 0;
    int burst_left     = 0;
    int cycle_count    = 0;

    indexed_list_store_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one operation to the shadow list and return the result it must produce.
    function automatic t_list_result apply_list_op(t_op op, logic signed [POS_W-1:0] pos,
                                                   logic signed [VAL_W-1:0] val);
        t_list_result res;
        int           p;
        int           i;
        res = '0;
        p   = int'(pos);
        if (!pos[POS_W-1]) begin
            case (op)
                OP_INSERT: begin
                    if (p <= shadow_len && shadow_len < ILS_CAPACITY) begin
                        for (i = shadow_len; i > p; i--)
                            shadow_entries[i] = shadow_entries[i-1];
                        shadow_entries[p] = val;
                        shadow_len++;
                        res.ok = 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (p < shadow_len) begin
                        for (i = p; i + 1 < shadow_len; i++)
                            shadow_entries[i] = shadow_entries[i+1];
                        shadow_len--;
                        res.ok = 1'b1;
                    end
                end
                OP_READ: begin
                    if (p < shadow_len) begin
                        res.rd = shadow_entries[p];
                        res.ok = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        res.len = shadow_len[LEN_W-1:0];
        return res;
    endfunction

    function automatic t_op any_list_op();
        case ($urandom_range(0, 2))
            0:       return OP_INSERT;
            1:       return OP_REMOVE;
            default: return OP_READ;
        endcase
    endfunction

    // Offer one item, hold it until the transfer, then queue its expected result.
    // Open a gap first when the current burst is used up.
    task automatic send_list_op(t_op op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                                logic fixed_want, t_list_result want);
        t_list_result predicted;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            // Mix short bursts with long unbroken stretches.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {val, pos};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        predicted = apply_list_op(op, pos, val);
        pending_results.push_back(fixed_want ? want : predicted);
    endtask

    // Draw one random item. Most items are well-formed for the current length,
    // biased toward growing or shrinking the list; the rest is noise.
    task automatic pick_list_op(input int ins_pct, input int rd_pct, output t_op op,
                                output logic [POS_W-1:0] pos, output logic [VAL_W-1:0] val);
        int roll;
        roll = $urandom_range(0, 99);
        val  = $urandom();
        if (roll < 6) begin
            case ($urandom_range(0, 2))
                0: begin
                    op  = OP_NONE;
                    pos = POS_W'($urandom());
                end
                1: begin
                    op  = any_list_op();
                    pos = {1'b1, 15'($urandom())};
                end
                default: begin
                    op  = any_list_op();
                    pos = POS_W'($urandom_range(shadow_len + 1, 32767));
                end
            endcase
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct) begin
                op   = OP_INSERT;
                roll = $urandom_range(0, 9);
                if (roll == 0)      pos = '0;
                else if (roll == 1) pos = POS_W'(shadow_len);
                else                pos = POS_W'($urandom_range(0, shadow_len));
            end else begin
                op = (roll < ins_pct + rd_pct) ? OP_READ : OP_REMOVE;
                // Hit the position just past the end now and then.
                if (shadow_len == 0 || $urandom_range(0, 9) == 0)
                    pos = POS_W'(shadow_len);
                else
                    pos = POS_W'($urandom_range(0, shadow_len - 1));
            end
        end
    endtask

    // Compare every output transfer with the oldest expected result.
    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got.ok  = m_axis_tuser;
            got.rd  = m_axis_tdata[VAL_W-1:0];
            got.len = m_axis_tdata[VAL_W+LEN_W-1:VAL_W];
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: ok=%0b value=%h length=%0d",
                             got.ok, got.rd, got.len);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d ok/value/length: expected %0b/%h/%0d, got %0b/%h/%0d",
                                 results_seen, want.ok, want.rd, want.len,
                                 got.ok, got.rd, got.len);
                end
            end
        end
    end

    // Receiver: stall in stretches of none, light or heavy back-pressure.
    // Once, early on, hold off long enough for the block to fill and stall its input.
    initial begin
        int  mode;
        bit  held;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && results_seen >= 30) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            mode = $urandom_range(0, 2);
            repeat (64) begin
                m_axis_tready <= (mode == 0) ? 1'b1
                               : ($urandom_range(0, 99) >= ((mode == 1) ? 25 : 60));
                @(posedge i_clk);
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_op              op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        int               random_sent;
        int               full_left;
        bit               reached_full;

        // Directed rows: empty-list failures, extremes of position and value,
        // the unused code, removal at the length leaving the head alone, then drain.
        dir_rows = '{
            '{OP_READ,   16'h0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 9'd0}},
            '{OP_REMOVE, 16'h0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 9'd0}},
            '{OP_INSERT, 16'h0001, 32'h1234_5678, 1'b1, '{1'b0, 32'h0, 9'd0}},
            '{OP_INSERT, 16'hFFFF, 32'h1234_5678, 1'b1, '{1'b0, 32'h0, 9'd0}},
            '{OP_NONE,   16'h0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 9'd0}},
            '{OP_INSERT, 16'h0000, 32'h7FFF_FFFF, 1'b1, '{1'b1, 32'h0, 9'd1}},
            '{OP_INSERT, 16'h0000, 32'h8000_0000, 1'b1, '{1'b1, 32'h0, 9'd2}},
            '{OP_INSERT, 16'h0002, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 9'd3}},
            '{OP_INSERT, 16'h0001, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 9'd4}},
            '{OP_READ,   16'h0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h8000_0000, 9'd4}},
            '{OP_READ,   16'h0003, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 9'd4}},
            '{OP_READ,   16'h0004, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 9'd4}},
            '{OP_REMOVE, 16'h0004, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 9'd4}},
            '{OP_READ,   16'h0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h8000_0000, 9'd4}},
            '{OP_READ,   16'h8000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 9'd4}},
            '{OP_INSERT, 16'h7FFF, 32'h5555_AAAA, 1'b1, '{1'b0, 32'h0, 9'd4}},
            '{OP_REMOVE, 16'h7FFF, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 9'd4}},
            '{OP_REMOVE, 16'h0001, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 9'd3}},
            '{OP_READ,   16'h0001, 32'h0000_0000, 1'b0, '0},
            '{OP_NONE,   16'h0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 9'd3}},
            '{OP_REMOVE, 16'h0002, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 9'd2}},
            '{OP_READ,   16'h0001, 32'h0000_0000, 1'b0, '0},
            '{OP_REMOVE, 16'h0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 9'd1}},
            '{OP_READ,   16'h0000, 32'h0000_0000, 1'b0, '0},
            '{OP_REMOVE, 16'h0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 9'd0}}
        };

        shadow_len    = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_INSERT;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            send_list_op(dir_rows[r].op, dir_rows[r].pos, dir_rows[r].val,
                         dir_rows[r].fixed_want, dir_rows[r].want);

        // Grow until the store is full, dwell at full, then shrink.
        random_sent  = 0;
        full_left    = FULL_ITEMS;
        reached_full = 1'b0;
        while (random_sent < RANDOM_ITEMS || !reached_full) begin
            if (shadow_len == ILS_CAPACITY)
                reached_full = 1'b1;
            if (!reached_full)
                pick_list_op(85, 10, op, pos, val);
            else if (full_left > 0) begin
                full_left--;
                pick_list_op(60, 20, op, pos, val);
            end else
                pick_list_op(15, 25, op, pos, val);
            send_list_op(op, pos, val, 1'b0, '0);
            random_sent++;
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow one worst-case operation for stray results.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (ILS_CAPACITY + 8) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
